// ----- hdl/ngbs_pkg.sv -----
// ----------------------------------------------------------------------------
// ngbs_pkg
// Shared types and constants of the trigram backoff score lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package ngbs_pkg;

  localparam int VOCAB_WORDS_DEF     = 16384;
  localparam int BIGRAM_ENTRIES_DEF  = 65536;
  localparam int TRIGRAM_ENTRIES_DEF = 65536;

  localparam int WORD_W    = 14;
  localparam int POS_W     = 16;
  localparam int LOG_W     = 16;
  localparam int CNT_W     = 17;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_UNI   = 2'd1,
    REQ_BI    = 2'd2,
    REQ_TRI   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ORD_UNI = 2'd0,
    ORD_BI  = 2'd1,
    ORD_TRI = 2'd2
  } order_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIGRAM_COUNT  = 2'd0,
    CFG_TRIGRAM_COUNT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    req_type_t                req_type;
    logic [POS_W-1:0]         entry_index;
    logic [WORD_W-1:0]        key_first_word;
    logic [WORD_W-1:0]        key_second_word;
    logic [WORD_W-1:0]        key_third_word;
    logic signed [LOG_W-1:0]  log_prob;
    logic signed [LOG_W-1:0]  log_backoff;
    logic [WORD_W-1:0]        new_word;
    logic [WORD_W-1:0]        hist_word;
    logic                     hist_word_valid;
    logic [POS_W-1:0]         hist_pair_index;
    logic                     hist_pair_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [LOG_W-1:0]  score;
    logic [WORD_W-1:0]        next_word;
    logic [POS_W-1:0]         next_pair_index;
    logic                     next_pair_valid;
    order_t                   order_used;
    logic                     is_query;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/ngbs_ram.sv -----
// ----------------------------------------------------------------------------
// ngbs_ram
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Addresses at or above DEPTH are dropped on write, read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ngbs_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (ADDR_W > 25) ? ADDR_W : 25;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;
  logic             rok_r;
  logic             w_ok;
  logic             r_ok;

  assign w_ok = CMP_W'(waddr) < CMP_W'(DEPTH);
  assign r_ok = CMP_W'(raddr) < CMP_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (we && w_ok) begin
      mem[IDX_W'(waddr)] <= wdata;
    end
    if (re) begin
      rd_r  <= mem[IDX_W'(raddr)];
      rok_r <= r_ok;
    end
  end

  assign rdata = rok_r ? rd_r : '0;

endmodule

`default_nettype wire

// ----- hdl/ngram_backoff_score_lookup.sv -----
// ----------------------------------------------------------------------------
// ngram_backoff_score_lookup
// Trigram backoff language model scorer with table load and query items.
// ----------------------------------------------------------------------------
// A write item updates one table entry and presents a zero acknowledgement once
// it reaches the done state. A query searches the key memories linearly, one
// entry per cycle through the single read port of each memory, and stops at
// the first match, scanning at most min(trigram_count, TRIGRAM_ENTRIES) +
// min(bigram_count, BIGRAM_ENTRIES) entries. One item is worked on at a
// time; the next one is taken while the previous result waits in the output
// register. No clearing pass is needed after reset.
`default_nettype none

module ngram_backoff_score_lookup #(
  parameter int VOCAB_WORDS     = ngbs_pkg::VOCAB_WORDS_DEF,
  parameter int BIGRAM_ENTRIES  = ngbs_pkg::BIGRAM_ENTRIES_DEF,
  parameter int TRIGRAM_ENTRIES = ngbs_pkg::TRIGRAM_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire ngbs_pkg::in_item_t             in_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output ngbs_pkg::out_item_t                 out_item,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ngbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ngbs_pkg::CNT_W-1:0]     cfg_data
);

  localparam int WW   = ngbs_pkg::WORD_W;
  localparam int PW   = ngbs_pkg::POS_W;
  localparam int LW   = ngbs_pkg::LOG_W;
  localparam int CW   = ngbs_pkg::CNT_W;
  localparam int AW   = 18;
  localparam int CMPW = 25;
  localparam int UNI_DW = 2 * LW;
  localparam int BI_DW  = 2 * WW + 2 * LW;
  localparam int TRI_DW = 3 * WW + LW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAIR_WT,
    S_TRI,
    S_BI,
    S_UNI_BW,
    S_UNI_PW,
    S_DONE
  } state_t;

  function automatic logic signed [AW-1:0] sext(input logic [LW-1:0] v);
    return {{(AW-LW){v[LW-1]}}, v};
  endfunction

  state_t                state_r;
  logic [CW-1:0]         bcount_r;
  logic [CW-1:0]         tcount_r;
  logic [WW-1:0]         nw_r;
  logic [WW-1:0]         hw_r;
  logic [WW-1:0]         mid_r;
  logic [WW-1:0]         bs_h_r;
  logic                  score_en_r;
  logic                  clr_r;
  logic signed [AW-1:0]  acc_r;
  logic [WW-1:0]         ow_r;
  logic [PW-1:0]         op_r;
  logic                  ov_r;
  ngbs_pkg::order_t      ord_r;
  logic                  is_q_r;
  logic [CW-1:0]         scan_cnt_r;
  logic                  chk_valid_r;
  logic [PW-1:0]         chk_idx_r;
  logic                  out_valid_r;
  ngbs_pkg::out_item_t   out_item_r;

  logic                  in_acc;
  logic [CW-1:0]         bi_n;
  logic [CW-1:0]         tri_n;
  logic [CW-1:0]         scan_n;
  logic                  scan_hit;
  logic                  scan_go;
  logic                  scan_miss;
  logic signed [LW-1:0]  score_sat;

  logic                  uni_we, uni_re;
  logic [PW-1:0]         uni_wa, uni_ra;
  logic [UNI_DW-1:0]     uni_wd, uni_rd;
  logic                  bi_we, bi_re;
  logic [CW-1:0]         bi_wa, bi_ra;
  logic [BI_DW-1:0]      bi_wd, bi_rd;
  logic                  tri_we, tri_re;
  logic [CW-1:0]         tri_wa, tri_ra;
  logic [TRI_DW-1:0]     tri_wd, tri_rd;

  ngbs_ram #(.DEPTH(VOCAB_WORDS), .WIDTH(UNI_DW), .ADDR_W(PW)) u_uni (
    .clk(clk), .we(uni_we), .waddr(uni_wa), .wdata(uni_wd),
    .re(uni_re), .raddr(uni_ra), .rdata(uni_rd)
  );

  ngbs_ram #(.DEPTH(BIGRAM_ENTRIES), .WIDTH(BI_DW), .ADDR_W(CW)) u_bi (
    .clk(clk), .we(bi_we), .waddr(bi_wa), .wdata(bi_wd),
    .re(bi_re), .raddr(bi_ra), .rdata(bi_rd)
  );

  ngbs_ram #(.DEPTH(TRIGRAM_ENTRIES), .WIDTH(TRI_DW), .ADDR_W(CW)) u_tri (
    .clk(clk), .we(tri_we), .waddr(tri_wa), .wdata(tri_wd),
    .re(tri_re), .raddr(tri_ra), .rdata(tri_rd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // search length stops at the table depth
  assign bi_n  = (CMPW'(bcount_r) < CMPW'(BIGRAM_ENTRIES)) ? bcount_r : CW'(BIGRAM_ENTRIES);
  assign tri_n = (CMPW'(tcount_r) < CMPW'(TRIGRAM_ENTRIES)) ? tcount_r : CW'(TRIGRAM_ENTRIES);
  assign scan_n = (state_r == S_TRI) ? tri_n : bi_n;

  always_comb begin
    if (state_r == S_TRI) begin
      scan_hit = chk_valid_r && (tri_rd[TRI_DW-1:LW] == {hw_r, mid_r, nw_r});
    end else begin
      scan_hit = chk_valid_r && (bi_rd[BI_DW-1:2*LW] == {bs_h_r, nw_r});
    end
  end

  // only the two search states walk the key memories
  assign scan_go   = ((state_r == S_TRI) || (state_r == S_BI)) &&
                     !scan_hit && (scan_cnt_r < scan_n);
  assign scan_miss = !scan_hit && !(scan_cnt_r < scan_n);

  // write ports: loaded straight from the accepted item
  assign uni_we = in_acc && (in_item.req_type == ngbs_pkg::REQ_UNI);
  assign uni_wa = in_item.entry_index;
  assign uni_wd = {in_item.log_prob, in_item.log_backoff};
  assign bi_we  = in_acc && (in_item.req_type == ngbs_pkg::REQ_BI);
  assign bi_wa  = CW'(in_item.entry_index);
  assign bi_wd  = {in_item.key_first_word, in_item.key_second_word,
                   in_item.log_prob, in_item.log_backoff};
  assign tri_we = in_acc && (in_item.req_type == ngbs_pkg::REQ_TRI);
  assign tri_wa = CW'(in_item.entry_index);
  assign tri_wd = {in_item.key_first_word, in_item.key_second_word,
                   in_item.key_third_word, in_item.log_prob};

  always_comb begin
    uni_re = 1'b0;
    uni_ra = '0;
    bi_re  = 1'b0;
    bi_ra  = '0;
    tri_re = 1'b0;
    tri_ra = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_item.req_type == ngbs_pkg::REQ_QUERY)) begin
          if (!in_item.hist_word_valid) begin
            uni_re = 1'b1;
            uni_ra = PW'(in_item.new_word);
          end else if ((tcount_r != '0) && in_item.hist_pair_valid) begin
            bi_re = 1'b1;
            bi_ra = CW'(in_item.hist_pair_index);
          end
        end
      end
      S_TRI: begin
        tri_re = scan_go;
        tri_ra = scan_cnt_r;
      end
      S_BI: begin
        bi_re = scan_go;
        bi_ra = scan_cnt_r;
        if (scan_miss && score_en_r) begin
          uni_re = 1'b1;
          uni_ra = (bcount_r != '0) ? PW'(bs_h_r) : PW'(nw_r);
        end
      end
      S_UNI_BW: begin
        uni_re = 1'b1;
        uni_ra = PW'(nw_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (acc_r > sext(16'h7FFF)) begin
      score_sat = 16'sh7FFF;
    end else if (acc_r < sext(16'h8000)) begin
      score_sat = 16'sh8000;
    end else begin
      score_sat = acc_r[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bcount_r    <= '0;
      tcount_r    <= '0;
      chk_valid_r <= 1'b0;
      scan_cnt_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ngbs_pkg::CFG_BIGRAM_COUNT) begin
          bcount_r <= cfg_data;
        end else if (cfg_index == ngbs_pkg::CFG_TRIGRAM_COUNT) begin
          tcount_r <= cfg_data;
        end
      end

      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      // advance the search pipeline: address issued now, compared next cycle
      if (scan_go) begin
        scan_cnt_r  <= scan_cnt_r + 1'b1;
        chk_valid_r <= 1'b1;
        chk_idx_r   <= PW'(scan_cnt_r);
      end else begin
        chk_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          scan_cnt_r <= '0;
          if (in_acc) begin
            nw_r  <= in_item.new_word;
            hw_r  <= in_item.hist_word;
            acc_r <= '0;
            ow_r  <= '0;
            op_r  <= '0;
            ov_r  <= 1'b0;
            ord_r <= ngbs_pkg::ORD_UNI;
            if (in_item.req_type != ngbs_pkg::REQ_QUERY) begin
              is_q_r  <= 1'b0;
              state_r <= S_DONE;
            end else begin
              is_q_r <= 1'b1;
              if (!in_item.hist_word_valid) begin
                ow_r    <= in_item.new_word;
                state_r <= S_UNI_PW;
              end else if ((tcount_r != '0) && in_item.hist_pair_valid) begin
                state_r <= S_PAIR_WT;
              end else begin
                bs_h_r     <= in_item.hist_word;
                score_en_r <= 1'b1;
                clr_r      <= (tcount_r == '0);
                state_r    <= S_BI;
              end
            end
          end
        end
        S_PAIR_WT: begin
          mid_r   <= bi_rd[2*LW +: WW];
          acc_r   <= sext(bi_rd[LW-1:0]);
          state_r <= S_TRI;
        end
        S_TRI: begin
          bs_h_r <= mid_r;
          clr_r  <= 1'b0;
          if (scan_hit) begin
            // trigram score replaces the pair backoff; only the history follows
            acc_r      <= sext(tri_rd[LW-1:0]);
            ord_r      <= ngbs_pkg::ORD_TRI;
            score_en_r <= 1'b0;
            scan_cnt_r <= '0;
            state_r    <= S_BI;
          end else if (scan_miss) begin
            score_en_r <= 1'b1;
            scan_cnt_r <= '0;
            state_r    <= S_BI;
          end
        end
        S_BI: begin
          if (scan_hit) begin
            ow_r    <= clr_r ? nw_r : bs_h_r;
            op_r    <= clr_r ? '0 : chk_idx_r;
            ov_r    <= !clr_r;
            state_r <= S_DONE;
            if (score_en_r) begin
              acc_r <= acc_r + sext(bi_rd[LW +: LW]);
              ord_r <= ngbs_pkg::ORD_BI;
            end
          end else if (scan_miss) begin
            ow_r <= nw_r;
            op_r <= '0;
            ov_r <= 1'b0;
            if (!score_en_r) begin
              state_r <= S_DONE;
            end else if (bcount_r != '0) begin
              state_r <= S_UNI_BW;
            end else begin
              state_r <= S_UNI_PW;
            end
          end
        end
        S_UNI_BW: begin
          acc_r   <= acc_r + sext(uni_rd[LW-1:0]);
          state_r <= S_UNI_PW;
        end
        S_UNI_PW: begin
          acc_r   <= acc_r + sext(uni_rd[LW +: LW]);
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r                <= 1'b1;
            out_item_r.score           <= score_sat;
            out_item_r.next_word       <= ow_r;
            out_item_r.next_pair_index <= op_r;
            out_item_r.next_pair_valid <= ov_r;
            out_item_r.order_used      <= ord_r;
            out_item_r.is_query        <= is_q_r;
            state_r                    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
